// ===== src/channel_pool_allocator_macros.svh =====
// assertion macros for the channel pool allocator
`ifndef CHANNEL_POOL_ALLOCATOR_MACROS_SVH
`define CHANNEL_POOL_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check, switched off while reset is high
`define CPA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define CPA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CPA_ASSERT(lbl, clk, rst, prop, msg)

`define CPA_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== src/cpa_pkg.sv =====
package cpa_pkg;

  // default pool depth
  localparam int unsigned MAX_CHANNELS_DEFAULT = 32;

  localparam int unsigned CHAN_W = 16;
  localparam int unsigned COUNT_OUT_W = 8;
  localparam int unsigned COUNT_SAT = 255;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ALLOCATE = 2'd1,
    CMD_FREE     = 2'd2,
    CMD_TAKE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_STATE = 3'd2,
    ST_FULL  = 3'd3,
    ST_NONE  = 3'd4
  } status_t;

endpackage

// ===== src/channel_pool_allocator.sv =====
// channel pool allocator: a command passes through the command register, then one pass of match,
// priority and update logic into the result register; the result register loads only when it is
// free or being emptied by rsp_ready, so a stalled result channel holds the command back
// throughput: one command per cycle while the result channel is not stalled
// reset: synchronous active-high rst clears the entry count, all taken bits and both valid flags
// the channel store itself is not cleared; slots at or above the entry count are never used

`include "channel_pool_allocator_macros.svh"

module channel_pool_allocator #(
  parameter int unsigned MAX_CHANNELS = cpa_pkg::MAX_CHANNELS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // command channel
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  logic [1:0]                     command,
  input  logic [cpa_pkg::CHAN_W-1:0]     channel_number,
  // result channel
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic                           success,
  output logic [2:0]                     status,
  output logic [cpa_pkg::CHAN_W-1:0]     taken_channel,
  output logic [cpa_pkg::CHAN_W-1:0]     first_free_channel,
  output logic                           any_free,
  output logic [cpa_pkg::COUNT_OUT_W-1:0] channel_count
);

  // entry count must be able to hold MAX_CHANNELS itself
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned CW    = cpa_pkg::CHAN_W;
  localparam int unsigned WIDE_W = CNT_W + cpa_pkg::COUNT_OUT_W;

  // ---------------------------------------------------------------------------
  // command register stage
  // ---------------------------------------------------------------------------
  logic                s_valid;
  cpa_pkg::cmd_t       s_cmd;
  logic [CW-1:0]       s_ch;
  logic                advance;

  // the result register is free or being emptied this cycle
  assign advance   = s_valid && (!rsp_valid || rsp_ready);
  assign cmd_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd_valid && cmd_ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      s_cmd <= cpa_pkg::cmd_t'(command);
      s_ch  <= channel_number;
    end
  end

  // ---------------------------------------------------------------------------
  // pool state: channel store (one slot per registered channel), taken bits,
  // fill count; a slot is in use when its index is below the count
  // ---------------------------------------------------------------------------
  logic [CW-1:0]           entry_channel [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] taken;
  logic [CNT_W-1:0]        count;

  // ---------------------------------------------------------------------------
  // single pass: associative match, first-free priority pick, update
  // ---------------------------------------------------------------------------
  logic [MAX_CHANNELS-1:0] used;
  logic [MAX_CHANNELS-1:0] match;
  logic [MAX_CHANNELS-1:0] free_before;
  logic [MAX_CHANNELS-1:0] ff_before;
  logic [MAX_CHANNELS-1:0] taken_next;
  logic [MAX_CHANNELS-1:0] app_sel;
  logic [MAX_CHANNELS-1:0] used_next;
  logic [MAX_CHANNELS-1:0] free_after;
  logic [MAX_CHANNELS-1:0] ff_after;
  logic [CW-1:0]           chan_next [MAX_CHANNELS];
  logic                    hit;
  logic                    hit_taken;
  logic                    full;
  logic                    append;
  logic                    ok;
  cpa_pkg::status_t        st;
  logic [CW-1:0]           tk_chan;
  logic [CW-1:0]           ff_chan;
  logic [CNT_W-1:0]        count_next;

  always_comb begin
    // slot occupancy and channel match lines
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      used[i]  = (CNT_W'(i) < count);
      match[i] = used[i] && (entry_channel[i] == s_ch);
    end
    hit         = |match;
    hit_taken   = |(match & taken);
    full        = (count == CNT_W'(MAX_CHANNELS));
    free_before = used & ~taken;
    // isolate lowest set bit
    ff_before   = free_before & (~free_before + MAX_CHANNELS'(1));

    ok         = 1'b0;
    st         = cpa_pkg::ST_OK;
    tk_chan    = '0;
    taken_next = taken;
    append     = 1'b0;

    if (s_cmd != cpa_pkg::CMD_TAKE && s_ch == '0) begin
      st = cpa_pkg::ST_ZERO;
    end else begin
      case (s_cmd)
        cpa_pkg::CMD_REGISTER, cpa_pkg::CMD_ALLOCATE: begin
          if (!hit) begin
            if (!full) begin
              append = 1'b1;
              ok     = 1'b1;
            end else begin
              st = cpa_pkg::ST_FULL;
            end
          end else if (s_cmd == cpa_pkg::CMD_ALLOCATE && !hit_taken) begin
            taken_next = taken | match;
            ok         = 1'b1;
          end else begin
            st = cpa_pkg::ST_STATE;
          end
        end
        cpa_pkg::CMD_FREE: begin
          if (hit_taken) begin
            taken_next = taken & ~match;
            ok         = 1'b1;
          end else begin
            st = cpa_pkg::ST_STATE;
          end
        end
        cpa_pkg::CMD_TAKE: begin
          if (|free_before) begin
            taken_next = taken | ff_before;
            ok         = 1'b1;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              tk_chan = tk_chan | ({CW{ff_before[i]}} & entry_channel[i]);
            end
          end else begin
            st = cpa_pkg::ST_NONE;
          end
        end
        default: begin
          st = cpa_pkg::ST_STATE;
        end
      endcase
    end

    // new slot goes at the current count
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      app_sel[i]   = append && (count == CNT_W'(i));
      chan_next[i] = app_sel[i] ? s_ch : entry_channel[i];
      used_next[i] = used[i] | app_sel[i];
      if (app_sel[i]) begin
        taken_next[i] = (s_cmd == cpa_pkg::CMD_ALLOCATE);
      end
    end
    count_next = count + CNT_W'(append);

    // first free slot after the update
    free_after = used_next & ~taken_next;
    ff_after   = free_after & (~free_after + MAX_CHANNELS'(1));
    ff_chan    = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      ff_chan = ff_chan | ({CW{ff_after[i]}} & chan_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
      count <= '0;
    end else if (advance) begin
      taken <= taken_next;
      count <= count_next;
    end
  end

  // channel store write on append
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (advance && app_sel[i]) begin
        entry_channel[i] <= s_ch;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic [WIDE_W-1:0] count_wide;
  logic [cpa_pkg::COUNT_OUT_W-1:0] count_sat;

  always_comb begin
    count_wide = WIDE_W'(count_next);
    if (count_wide > WIDE_W'(cpa_pkg::COUNT_SAT)) begin
      count_sat = cpa_pkg::COUNT_OUT_W'(cpa_pkg::COUNT_SAT);
    end else begin
      count_sat = count_wide[cpa_pkg::COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      success            <= ok;
      status             <= st;
      taken_channel      <= tk_chan;
      first_free_channel <= ff_chan;
      any_free           <= |free_after;
      channel_count      <= count_sat;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CPA_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(MAX_CHANNELS), "entry count beyond pool depth")
  `CPA_ASSERT(a_taken_in_use, clk, rst, (taken & ~used) == '0, "taken bit set on unused slot")
  `CPA_ASSERT(a_hold_state, clk, rst, !advance |=> $stable(count) && $stable(taken), "pool state changed without a transaction")
  `CPA_ASSERT(a_free_chan, clk, rst, rsp_valid |-> (any_free == (first_free_channel != '0)), "first free channel disagrees with any_free")

endmodule
